[hdl/iconv_pkg.sv]
`timescale 1ns / 1ps
package iconv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int KSIZE      = 5;
    localparam int TAPS       = 5;
    localparam int HALF       = KSIZE / 2;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 12;
    localparam int CFG_W      = 60;
    localparam int CIDX_W     = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = 13;
    localparam int IDX_W      = 15;
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SEL_W      = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int ODEPTH     = 8;
    localparam int OPTR_W     = $clog2(ODEPTH);
    localparam int OCNT_W     = OPTR_W + 1;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int RSUM_W     = PROD_W + 3;
    localparam int SUM_W      = RSUM_W + 3;
    localparam int SHIFT      = 8;
    localparam int OUT_W      = 16;

    typedef enum logic [CIDX_W-1:0] {
        REG_KROW0,
        REG_KROW1,
        REG_KROW2,
        REG_KROW3,
        REG_KROW4,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_reg_e;

    typedef logic [TAPS-1:0][PIX_W-1:0] pix_col_t;
    typedef logic [TAPS-1:0][CFG_W-1:0] kernel_t;

    typedef struct packed {
        pix_col_t               pix;
        logic                   due;
        logic                   last;
        logic [COL_W-1:0]       col;
        logic [WID_W-1:0]       width;
    } col_rec_t;

    // asymmetric mirror: -k reads k, n+k reads n-1-k
    function automatic logic signed [IDX_W-1:0] mirror_idx(
        input logic signed [IDX_W-1:0] v,
        input logic signed [IDX_W-1:0] n
    );
        logic signed [IDX_W-1:0] r;
        if (v < 0)
        begin
            r = -v;
        end
        else if (v >= n)
        begin
            r = (n <<< 1) - v - IDX_W'(1);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/iconv_queue.sv]
`timescale 1ns / 1ps
module iconv_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  iconv_pkg::col_rec_t         din,
    input  logic                        pop,
    output iconv_pkg::col_rec_t         dout,
    output logic                        empty,
    output logic [iconv_pkg::QCNT_W-1:0] count
);
    import iconv_pkg::*;

    col_rec_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QCNT_W'(QDEPTH))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");
`endif

endmodule

[hdl/iconv_front.sv]
`timescale 1ns / 1ps
module iconv_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         cmd,
    input  logic [iconv_pkg::PIX_W-1:0]  pixel,
    input  logic [iconv_pkg::WID_W-1:0]  width_cfg,
    input  logic [iconv_pkg::HGT_W-1:0]  height_cfg,
    input  logic [iconv_pkg::QCNT_W-1:0] q_count,
    output logic                         rec_valid,
    output iconv_pkg::col_rec_t          rec
);
    import iconv_pkg::*;

    logic [SLOTS*PIX_W-1:0] store_mem [MAX_WIDTH];
    logic [SLOTS*PIX_W-1:0] rd_reg;

    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             s1_valid_reg;

    logic [TAPS-1:0][SLOT_W-1:0] s1_slot_reg, s1_slot_next;
    logic [TAPS-1:0]             s1_byp_reg, s1_byp_next;
    logic [PIX_W-1:0]            s1_px_reg;
    logic                        s1_due_reg;
    logic                        s1_last_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic [WID_W-1:0]            s1_width_reg;

    logic [WID_W-1:0]   w;
    logic [HGT_W-1:0]   h;
    logic               acc;
    logic               clr;
    logic [ROW_W-1:0]   ri, ro;
    logic [COL_W-1:0]   ci, co;
    logic               wr;
    logic [PIX_W-1:0]   px;
    logic signed [ROW_W:0] dr;
    logic               due;
    logic               last_px;
    logic [WID_W-1:0]   ci_inc, co_inc;
    logic [QCNT_W:0]    occ;
    logic signed [IDX_W-1:0] ri_s, h_s, v, m;

    always_comb
    begin
        w = (width_cfg < WID_W'(3)) ? WID_W'(3) :
            (width_cfg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_cfg;
        h = (height_cfg < HGT_W'(3)) ? HGT_W'(3) :
            (height_cfg > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : height_cfg;

        occ  = {1'b0, q_count} + (QCNT_W+1)'(s1_valid_reg);
        full = (occ >= (QCNT_W+1)'(QDEPTH));
        acc  = push && !full;

        clr = ({1'b0, in_col_reg} >= w) || ({1'b0, out_col_reg} >= w) ||
              (out_row_reg >= h) || ({1'b0, in_row_reg} >= ({1'b0, h} + (HGT_W+1)'(3)));
        ri = clr ? '0 : in_row_reg;
        ci = clr ? '0 : in_col_reg;
        ro = clr ? '0 : out_row_reg;
        co = clr ? '0 : out_col_reg;

        wr = (ri < h);
        px = cmd ? '0 : pixel;

        // in_idx >= out_idx + 2w + 2, worked out per row distance
        dr  = $signed({1'b0, ri}) - $signed({1'b0, ro});
        due = (dr >= (ROW_W+1)'(4)) ||
              ((dr == (ROW_W+1)'(3)) &&
               (({2'b0, ci} + {1'b0, w}) >= ({2'b0, co} + (WID_W+1)'(2)))) ||
              ((dr == (ROW_W+1)'(2)) && ({1'b0, ci} >= ({1'b0, co} + WID_W'(2))));
        last_px = due && (ro == ROW_W'(h - HGT_W'(1))) && ({1'b0, co} == (w - WID_W'(1)));

        ci_inc = {1'b0, ci} + WID_W'(1);
        co_inc = {1'b0, co} + WID_W'(1);

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (acc)
        begin
            if (last_px)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
            else
            begin
                in_col_next = (ci_inc >= w) ? '0 : ci_inc[COL_W-1:0];
                in_row_next = (ci_inc >= w) ? ri + ROW_W'(1) : ri;
                out_col_next = co;
                out_row_next = ro;
                if (due)
                begin
                    out_col_next = (co_inc >= w) ? '0 : co_inc[COL_W-1:0];
                    out_row_next = (co_inc >= w) ? ro + ROW_W'(1) : ro;
                end
            end
        end

        // rows of output row ri-2, mirrored at the top and bottom edges
        ri_s = $signed({{(IDX_W-ROW_W){1'b0}}, ri});
        h_s  = $signed({{(IDX_W-HGT_W){1'b0}}, h});
        for (int d = 0; d < TAPS; d++)
        begin
            v = ri_s - IDX_W'(4) + IDX_W'(d);
            m = mirror_idx(v, h_s);
            s1_slot_next[d] = m[SLOT_W-1:0];
            s1_byp_next[d]  = (m == ri_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_slot_reg  <= s1_slot_next;
            s1_byp_reg   <= s1_byp_next;
            s1_px_reg    <= px;
            s1_due_reg   <= due;
            s1_last_reg  <= last_px;
            s1_col_reg   <= co;
            s1_width_reg <= w;
        end
    end

    // line store: one column per word, one byte per row slot
    always_ff @(posedge clk)
    begin
        if (acc && wr)
        begin
            store_mem[ci][ri[SLOT_W-1:0]*PIX_W +: PIX_W] <= px;
        end
        if (acc)
        begin
            rd_reg <= store_mem[ci];
        end
    end

    always_comb
    begin
        for (int d = 0; d < TAPS; d++)
        begin
            rec.pix[d] = s1_byp_reg[d] ? s1_px_reg :
                         rd_reg[s1_slot_reg[d]*PIX_W +: PIX_W];
        end
        rec.due   = s1_due_reg;
        rec.last  = s1_last_reg;
        rec.col   = s1_col_reg;
        rec.width = s1_width_reg;
    end

    assign rec_valid = s1_valid_reg;

`ifndef ASSERT_OFF
    a_last_is_due: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> s1_due_reg)
        else $error("last flag without an output");
`endif

endmodule

[hdl/iconv_back.sv]
`timescale 1ns / 1ps
module iconv_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iconv_pkg::kernel_t                kernel,
    input  logic                              q_empty,
    input  iconv_pkg::col_rec_t               q_dout,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [iconv_pkg::OUT_W-1:0] filtered,
    output logic                              last
);
    import iconv_pkg::*;

    pix_col_t                                col_reg [TAPS];
    pix_col_t                                src [TAPS];
    logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0]    win_reg, win_next;
    logic signed [PROD_W-1:0]                prod_reg [TAPS][TAPS];
    logic signed [RSUM_W-1:0]                rsum_reg [TAPS];
    logic                                    v_w_reg, v_m_reg, v_r_reg;
    logic                                    l_w_reg, l_m_reg, l_r_reg;

    logic [OUT_W:0]      ofifo_reg [ODEPTH];
    logic [OPTR_W-1:0]   o_wr_reg, o_rd_reg;
    logic [OCNT_W-1:0]   o_cnt_reg, o_cnt_next;
    logic [OCNT_W:0]     occ;
    logic                o_pop;

    logic signed [IDX_W-1:0] c_s, w_s, v, m, k;
    logic [SEL_W-1:0]        sel;
    logic signed [COEF_W-1:0] coef [TAPS][TAPS];
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-SHIFT-1:0] shifted;
    logic signed [OUT_W-1:0]  sat;

    always_comb
    begin
        occ   = {1'b0, o_cnt_reg} + (OCNT_W+1)'(v_w_reg) + (OCNT_W+1)'(v_m_reg) +
                (OCNT_W+1)'(v_r_reg);
        q_pop = !q_empty && (occ < (OCNT_W+1)'(ODEPTH));

        src[0] = q_dout.pix;
        for (int i = 1; i < TAPS; i++)
        begin
            src[i] = col_reg[i-1];
        end

        // column taps mirrored at the left and right edges
        c_s = $signed({{(IDX_W-COL_W){1'b0}}, q_dout.col});
        w_s = $signed({{(IDX_W-WID_W){1'b0}}, q_dout.width});
        for (int j = 0; j < TAPS; j++)
        begin
            v   = c_s + IDX_W'(j) - IDX_W'(2);
            m   = mirror_idx(v, w_s);
            k   = c_s + IDX_W'(2) - m;
            sel = k[SEL_W-1:0];
            for (int i = 0; i < TAPS; i++)
            begin
                unique case (sel)
                    3'd0:    win_next[i][j] = src[0][i];
                    3'd1:    win_next[i][j] = src[1][i];
                    3'd2:    win_next[i][j] = src[2][i];
                    3'd3:    win_next[i][j] = src[3][i];
                    3'd4:    win_next[i][j] = src[4][i];
                    default: win_next[i][j] = '0;
                endcase
            end
        end

        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                coef[i][j] = ((i - 2 < -HALF) || (i - 2 > HALF) || (j - 2 < -HALF) ||
                              (j - 2 > HALF)) ? '0 : $signed(kernel[i][j*COEF_W +: COEF_W]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            col_reg[0] <= q_dout.pix;
            for (int i = 1; i < TAPS; i++)
            begin
                col_reg[i] <= col_reg[i-1];
            end
            win_reg <= win_next;
            l_w_reg <= q_dout.last;
        end
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                prod_reg[i][j] <= PROD_W'(coef[i][j] * $signed({1'b0, win_reg[i][j]}));
            end
        end
        l_m_reg <= l_w_reg;
        for (int i = 0; i < TAPS; i++)
        begin
            rsum_reg[i] <= RSUM_W'(prod_reg[i][0]) + RSUM_W'(prod_reg[i][1]) +
                           RSUM_W'(prod_reg[i][2]) + RSUM_W'(prod_reg[i][3]) +
                           RSUM_W'(prod_reg[i][4]);
        end
        l_r_reg <= l_m_reg;
    end

    always_comb
    begin
        total = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]) +
                SUM_W'(rsum_reg[3]) + SUM_W'(rsum_reg[4]);
        shifted = total[SUM_W-1:SHIFT];
        if (shifted > $signed((SUM_W-SHIFT)'(32767)))
        begin
            sat = 16'sh7FFF;
        end
        else if (shifted < -$signed((SUM_W-SHIFT)'(32768)))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = shifted[OUT_W-1:0];
        end
        o_pop      = pop && (o_cnt_reg != '0);
        o_cnt_next = o_cnt_reg + OCNT_W'(v_r_reg) - OCNT_W'(o_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_w_reg   <= 1'b0;
            v_m_reg   <= 1'b0;
            v_r_reg   <= 1'b0;
            o_wr_reg  <= '0;
            o_rd_reg  <= '0;
            o_cnt_reg <= '0;
        end
        else
        begin
            v_w_reg   <= q_pop && q_dout.due;
            v_m_reg   <= v_w_reg;
            v_r_reg   <= v_m_reg;
            o_wr_reg  <= v_r_reg ? o_wr_reg + OPTR_W'(1) : o_wr_reg;
            o_rd_reg  <= o_pop ? o_rd_reg + OPTR_W'(1) : o_rd_reg;
            o_cnt_reg <= o_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_r_reg)
        begin
            ofifo_reg[o_wr_reg] <= {l_r_reg, sat};
        end
    end

    assign empty    = (o_cnt_reg == '0);
    assign filtered = ofifo_reg[o_rd_reg][OUT_W-1:0];
    assign last     = ofifo_reg[o_rd_reg][OUT_W];

`ifndef ASSERT_OFF
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        v_r_reg |-> o_cnt_reg < OCNT_W'(ODEPTH))
        else $error("result queue overflow");
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> ({1'b0, o_cnt_reg} + (OCNT_W+1)'(v_m_reg) + (OCNT_W+1)'(v_r_reg))
                  <= (OCNT_W+1)'(ODEPTH))
        else $error("pipeline outran result space");
`endif

endmodule

[hdl/image_convolution_mirror_border.sv]
`timescale 1ns / 1ps
// 5x5 convolution over a raster pixel stream, mirrored borders.
// Input queue side: push/full with cmd and pixel; cmd=1 is a drain item.
// Result queue side: empty/pop with filtered (signed 16) and last.
// Config: cfg_we/cfg_index/cfg_data; rows 0..4 of Q3.8 kernel, then width,
// height. Write only while no transfer is in progress.
// The result for pixel (r,c) follows the item at raster (r+2,c+2), i.e.
// 2*width+2 items later; feed 2*width+2 drain items after the last pixel.
// Throughput: one item per clock while full is low. A result reaches the ports
// after the item that completes its window has been transferred: line store read
// on the transfer edge, then the column queue, window select, multiply and
// row sums, with the final sum written into the result queue.
// Reset clears the position counters and loads the reset kernel (1.0 at
// row 2, column 0), width 640 and height 480; the line store needs no clearing.
// When pop stays low the result queue (8 deep) fills, the back end stops
// taking columns, the 4-deep column queue fills and full rises.
module image_convolution_mirror_border (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                cmd,
    input  logic [iconv_pkg::PIX_W-1:0]         pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [iconv_pkg::OUT_W-1:0]  filtered,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [iconv_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [iconv_pkg::CFG_W-1:0]         cfg_data
);
    import iconv_pkg::*;

    kernel_t            kernel_reg, kernel_next;
    logic [WID_W-1:0]   width_reg, width_next;
    logic [HGT_W-1:0]   height_reg, height_next;

    logic               rec_valid;
    col_rec_t           rec;
    col_rec_t           q_dout;
    logic               q_empty;
    logic               q_pop;
    logic [QCNT_W-1:0]  q_count;

    always_comb
    begin
        kernel_next = kernel_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_KROW0:  kernel_next[0] = cfg_data;
                REG_KROW1:  kernel_next[1] = cfg_data;
                REG_KROW2:  kernel_next[2] = cfg_data;
                REG_KROW3:  kernel_next[3] = cfg_data;
                REG_KROW4:  kernel_next[4] = cfg_data;
                REG_WIDTH:  width_next     = cfg_data[WID_W-1:0];
                REG_HEIGHT: height_next    = cfg_data[HGT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= {CFG_W'(0), CFG_W'(0), CFG_W'(256), CFG_W'(0), CFG_W'(0)};
            width_reg  <= WID_W'(640);
            height_reg <= HGT_W'(480);
        end
        else
        begin
            kernel_reg <= kernel_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    iconv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .pixel      (pixel),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .q_count    (q_count),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    iconv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_valid),
        .din   (rec),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    iconv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .kernel   (kernel_reg),
        .q_empty  (q_empty),
        .q_dout   (q_dout),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .filtered (filtered),
        .last     (last)
    );

endmodule

[bench/image_convolution_mirror_border_tb.sv]
`timescale 1ns / 1ps
module image_convolution_mirror_border_tb;
    import iconv_pkg::*;

    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] px;
    } px_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    last;
    } conv_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     cmd = 1'b0;
    logic [PIX_W-1:0]         pixel = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [OUT_W-1:0]  filtered;
    logic                     last;
    logic                     cfg_we = 1'b0;
    logic [CIDX_W-1:0]        cfg_index = REG_KROW0;
    logic [CFG_W-1:0]         cfg_data = '0;

    px_item_t    pend_px[$];
    conv_out_t   want_q[$];
    int          err_cnt = 0;
    bit          took_in = 1'b0;
    bit          steady = 1'b0;
    bit          hold_in = 1'b0;
    int          sent_items = 0;

    // mirror of block state
    logic [CFG_W-1:0] krow[5] = '{0, 0, 256, 0, 0};
    logic [WID_W-1:0] cur_wcfg = 11'd640;
    logic [HGT_W-1:0] cur_hcfg = 13'd480;
    logic [PIX_W-1:0] rows_mem[6*MAX_WIDTH];
    int unsigned      in_r = 0, in_c = 0, out_r = 0, out_c = 0;

    image_convolution_mirror_border i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .filtered  (filtered),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int used_w(input logic [WID_W-1:0] v);
        return (v < 3) ? 3 : (v > MAX_WIDTH) ? MAX_WIDTH : int'(v);
    endfunction

    function automatic int used_h(input logic [HGT_W-1:0] v);
        return (v < 3) ? 3 : (v > MAX_HEIGHT) ? MAX_HEIGHT : int'(v);
    endfunction

    function automatic int reflect(input int k, input int n);
        if (k < 0)
            return -k;
        if (k >= n)
            return 2 * n - 1 - k;
        return k;
    endfunction

    function automatic int weight(input int dr, input int dc);
        logic signed [COEF_W-1:0] c;
        if (dr < -HALF || dr > HALF || dc < -HALF || dc > HALF)
            return 0;
        c = krow[dr + 2][COEF_W * (dc + 2) +: COEF_W];
        return int'(c);
    endfunction

    function automatic logic signed [OUT_W-1:0] window_sum(input int r, input int c,
                                                           input int w, input int h);
        int acc;
        int rr;
        acc = 0;
        for (int dr = -2; dr <= 2; dr++)
        begin
            rr = reflect(r + dr, h) % 6;
            for (int dc = -2; dc <= 2; dc++)
                acc += weight(dr, dc) * int'(rows_mem[rr * MAX_WIDTH + reflect(c + dc, w)]);
        end
        acc = acc >>> SHIFT;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return OUT_W'(acc);
    endfunction

    task automatic convolve_step(input logic c_in, input logic [PIX_W-1:0] p_in);
        int unsigned w;
        int unsigned h;
        conv_out_t   o;
        w = used_w(cur_wcfg);
        h = used_h(cur_hcfg);
        if (in_c >= w || out_c >= w || out_r >= h || in_r >= h + 3)
        begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
        if (in_r < h)
            rows_mem[(in_r % 6) * MAX_WIDTH + in_c] = c_in ? '0 : p_in;
        if (in_r * w + in_c >= out_r * w + out_c + 2 * w + 2)
        begin
            o.value = window_sum(out_r, out_c, w, h);
            o.last = (out_r == h - 1) && (out_c == w - 1);
            want_q = {want_q, o};
            if (o.last)
            begin
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
                return;
            end
            out_c++;
            if (out_c >= w)
            begin
                out_c = 0;
                out_r++;
            end
        end
        in_c++;
        if (in_c >= w)
        begin
            in_c = 0;
            in_r++;
        end
    endtask

    always @(posedge clk)
    begin
        took_in = rst_n && push && !full;
        if (took_in)
            convolve_step(cmd, pixel);
        if (rst_n && pop && !empty)
        begin
            if (want_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected transfer: filtered=%0d last=%0b", filtered, last);
            end
            else if (filtered !== want_q[0].value || last !== want_q[0].last)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
                             want_q[0].value, filtered, want_q[0].last, last);
                void'(want_q.pop_front());
            end
            else
                void'(want_q.pop_front());
        end
    end

    always @(negedge clk)
    begin
        px_item_t it;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || took_in)
        begin
            if (pend_px.size() > 0 && !hold_in && (steady || $urandom_range(0, 99) >= 25))
            begin
                it = pend_px.pop_front();
                push <= 1'b1;
                cmd <= it.cmd;
                pixel <= it.px;
                sent_items++;
            end
            else
                push <= 1'b0;
        end
        pop <= rst_n && (steady || $urandom_range(0, 99) >= 25);
    end

    task automatic settle();
        wait (pend_px.size() == 0 && !push && want_q.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx <= REG_KROW4)
            krow[int'(idx)] = v;
        else if (idx == REG_WIDTH)
            cur_wcfg = v[WID_W-1:0];
        else
            cur_hcfg = v[HGT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_row();
        return CFG_W'({$urandom, $urandom});
    endfunction

    task automatic load_kernel(input int mode);
        cfg_reg_e r;
        for (int i = 0; i < 5; i++)
        begin
            r = cfg_reg_e'(i);
            case (mode)
                0: write_reg(r, {5{12'h7FF}});
                1: write_reg(r, {5{12'h800}});
                2: write_reg(r, '0);
                3: write_reg(r, {CFG_W{1'b1}});
                default: write_reg(r, rand_row());
            endcase
        end
    endtask

    // full image plus tail, or npix items if given; drains and stray pixels mixed
    task automatic queue_image(input logic [WID_W-1:0] wv, input logic [HGT_W-1:0] hv,
                               input int npix);
        px_item_t it;
        int       w;
        int       total;
        w = used_w(wv);
        total = (npix >= 0) ? npix : used_h(hv) * w + 2 * w + 2;
        write_reg(REG_WIDTH, CFG_W'(wv));
        write_reg(REG_HEIGHT, CFG_W'(hv));
        for (int i = 0; i < total; i++)
        begin
            if (i < used_h(hv) * w)
                it.cmd = ($urandom_range(0, 9) == 0);
            else
                it.cmd = 1'($urandom_range(0, 1));
            it.px = PIX_W'($urandom_range(0, 255));
            pend_px = {pend_px, it};
        end
    endtask

    initial
    begin
        px_item_t it;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset kernel on a tiny frame, extreme pixel values
        write_reg(REG_WIDTH, CFG_W'(11'd3));
        write_reg(REG_HEIGHT, CFG_W'(13'd3));
        for (int i = 0; i < 17; i++)
        begin
            it.cmd = (i >= 9) ? 1'(i % 2) : (i == 4);
            it.px = (i % 2) ? 8'hFF : 8'h00;
            pend_px = {pend_px, it};
        end
        settle();
        load_kernel(0);
        queue_image(11'd3, 13'd3, -1);
        settle();
        load_kernel(1);
        queue_image(11'd4, 13'd3, -1);
        settle();
        load_kernel(3);
        queue_image(11'd0, 13'd1, -1);

        // interrupted frame, then a width that forces a counter restart
        settle();
        load_kernel(4);
        queue_image(11'd8, 13'd6, 30);
        settle();
        queue_image(11'd5, 13'd4, -1);

        // clamped extremes, short partial frames
        settle();
        load_kernel(4);
        queue_image(11'd2047, 13'd2, 40);
        settle();
        queue_image(11'd2, 13'd8191, 60);
        settle();
        load_kernel(2);
        queue_image(11'd6, 13'd3, -1);

        for (int n = 0; sent_items + pend_px.size() < 900; n++)
        begin
            settle();
            steady = (n >= 4 && n < 8);
            load_kernel((n % 9 == 0) ? $urandom_range(0, 1) : 4);
            queue_image(WID_W'($urandom_range(3, 10)), HGT_W'($urandom_range(3, 8)), -1);
            if (n == 3)
            begin
                wait (pend_px.size() < 20);
                hold_in = 1'b1;
                wait (want_q.size() == 0);
                repeat (12) @(posedge clk);
                hold_in = 1'b0;
            end
        end
        steady = 1'b0;
        settle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hdl/iconv_pkg.sv
hdl/iconv_queue.sv
hdl/iconv_front.sv
hdl/iconv_back.sv
hdl/image_convolution_mirror_border.sv
bench/image_convolution_mirror_border_tb.sv
